// ===== design/tlgs_pkg.sv =====
// Package for the toroidal Life generation step block.
// Holds the controller state type and the 3x3 neighborhood type shared
// by the row evaluator and the cell lanes. No dependencies.
package tlgs_pkg;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } t_state;

    // Each row slice is {right, center, left} relative to the lane column.
    typedef struct packed {
        logic [2:0] up;
        logic [2:0] mid;
        logic [2:0] dn;
    } t_nbhd;

    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

endpackage

// ===== design/tlgs_cell.sv =====
// One lane of the row evaluator: applies the B3/S23 rule to one column.
// Depends on tlgs_pkg for the neighborhood type and rule constants.
module tlgs_cell (
    input  tlgs_pkg::t_nbhd i_nbhd,
    output logic            o_alive
);

    logic [3:0] count;

    always_comb begin
        count = 4'($countones({i_nbhd.up, i_nbhd.mid[2], i_nbhd.mid[0], i_nbhd.dn}));
        o_alive = (count == tlgs_pkg::BIRTH_COUNT) ||
                  ((count == tlgs_pkg::SURVIVE_COUNT) && i_nbhd.mid[1]);
    end

endmodule

// ===== design/tlgs_row_eval.sv =====
// Row evaluator: one tlgs_cell lane per column and the merge of their results.
// Depends on tlgs_pkg and tlgs_cell.
module tlgs_row_eval #(
    parameter int W     = 64,
    parameter int IDX_W = 6
) (
    input  logic [W-1:0]     i_up,
    input  logic [W-1:0]     i_mid,
    input  logic [W-1:0]     i_dn,
    input  logic [IDX_W-1:0] i_last_col,
    input  logic [W-1:0]     i_side_mask,
    output logic [W-1:0]     o_row
);

    logic [W-1:0] alive;

    for (genvar x = 0; x < W; x++) begin : g_lane
        localparam int XL = (x == 0) ? 0 : x - 1;
        localparam int XR = (x == W - 1) ? 0 : x + 1;
        logic [2:0]      sel_up, sel_mid, sel_dn;
        tlgs_pkg::t_nbhd nbhd;
        logic            wrap_l, wrap_r;

        // Column neighbors wrap at the current side, not at the lane count.
        assign wrap_l = (x == 0);
        assign wrap_r = (i_last_col == IDX_W'(x)) || (x == W - 1);

        assign sel_up  = {wrap_r ? i_up[0]  : i_up[XR],  i_up[x],
                          wrap_l ? i_up[i_last_col]  : i_up[XL]};
        assign sel_mid = {wrap_r ? i_mid[0] : i_mid[XR], i_mid[x],
                          wrap_l ? i_mid[i_last_col] : i_mid[XL]};
        assign sel_dn  = {wrap_r ? i_dn[0]  : i_dn[XR],  i_dn[x],
                          wrap_l ? i_dn[i_last_col]  : i_dn[XL]};

        assign nbhd.up  = sel_up;
        assign nbhd.mid = sel_mid;
        assign nbhd.dn  = sel_dn;

        tlgs_cell u_cell (
            .i_nbhd  (nbhd),
            .o_alive (alive[x])
        );
    end

    assign o_row = alive & i_side_mask;

endmodule

// ===== design/toroidal_life_generation_step_core.sv =====
// Top level of the toroidal Life generation step; holds the row memory,
// the load/emit sequencer and the output register. Depends on tlgs_pkg
// and tlgs_row_eval.
//
// The block loads a square grid of side 2^side_log2 (capped at the largest
// power of two not above MAX_SIDE) one row per input transfer, one row per
// cycle. The transfer of the last row starts emission: the next generation
// leaves one row per cycle while the receiver is ready, row 0 first, with
// last_row set on the final row, while the input side is held off. Loading
// and emission never overlap. During emission a three-row window read from
// the row memory feeds MAX_SIDE parallel cell lanes. Writing side_log2
// restarts loading at row 0 and must happen only while no generation is in
// flight.
module toroidal_life_generation_step_core #(
    parameter int MAX_SIDE = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_side_log2,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_row_cells,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_next_row_cells,
    output logic        o_last_row
);

    localparam int W        = MAX_SIDE;
    localparam int IDX_W    = $clog2(MAX_SIDE);
    localparam int MAX_LOG2 = $clog2(MAX_SIDE + 1) - 1;

    tlgs_pkg::t_state r_state, n_state;

    logic [2:0]       r_side_log2;
    logic [IDX_W-1:0] r_rows_loaded;
    logic [IDX_W-1:0] r_y;
    logic [W-1:0]     r_mem [MAX_SIDE];
    logic [W-1:0]     r_up, r_mid, r_dn;
    logic             r_out_valid;
    logic [W-1:0]     r_out_row;
    logic             r_out_last;

    logic [2:0]       side_lg;
    logic [IDX_W-1:0] last_idx;
    logic [IDX_W:0]   side;
    logic [W-1:0]     side_mask;
    logic [W-1:0]     in_row;
    logic [W-1:0]     eval_row;
    logic [IDX_W-1:0] rd_addr;
    logic             in_xfer;
    logic             cfg_xfer;
    logic             load_done;
    logic             advance;

    // Current side, capped to what the memory holds.
    always_comb begin
        side_lg   = (r_side_log2 > 3'(MAX_LOG2)) ? 3'(MAX_LOG2) : r_side_log2;
        last_idx  = ~({IDX_W{1'b1}} << side_lg);
        side      = {1'b0, last_idx} + (IDX_W + 1)'(1);
        side_mask = ~({W{1'b1}} << side);
        in_row    = i_row_cells[W-1:0] & side_mask;
        rd_addr   = (r_y + IDX_W'(2)) & last_idx;
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tlgs_pkg::ST_LOAD: begin
                if (i_valid && (r_rows_loaded == last_idx)) begin
                    n_state = tlgs_pkg::ST_EMIT;
                end
            end
            tlgs_pkg::ST_EMIT: begin
                if ((!r_out_valid || i_ready) && (r_y == last_idx)) begin
                    n_state = tlgs_pkg::ST_LOAD;
                end
            end
            default: n_state = tlgs_pkg::ST_LOAD;
        endcase
    end

    // Output and control decode.
    always_comb begin
        o_ready = 1'b0;
        advance = 1'b0;
        unique case (r_state)
            tlgs_pkg::ST_LOAD: o_ready = 1'b1;
            tlgs_pkg::ST_EMIT: advance = !r_out_valid || i_ready;
            default: begin
                o_ready = 1'b0;
                advance = 1'b0;
            end
        endcase
        in_xfer   = i_valid && o_ready;
        load_done = in_xfer && (r_rows_loaded == last_idx);
        cfg_xfer  = i_cfg_valid;
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= tlgs_pkg::ST_LOAD;
            r_side_log2   <= 3'd6;
            r_rows_loaded <= '0;
            r_y           <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            // A register write restarts loading and takes precedence.
            if (cfg_xfer) begin
                r_side_log2   <= i_cfg_side_log2;
                r_rows_loaded <= '0;
            end else if (load_done) begin
                r_rows_loaded <= '0;
            end else if (in_xfer) begin
                r_rows_loaded <= r_rows_loaded + IDX_W'(1);
            end
            if (load_done) begin
                r_y <= '0;
            end else if (advance) begin
                r_y <= r_y + IDX_W'(1);
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Row memory and the three-row window that slides over it.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_mem[r_rows_loaded] <= in_row;
        end
        if (load_done) begin
            // The row just transferred is the last one, so it is the wrapped
            // neighbor above row 0; small grids take it for rows 0 and 1 too.
            r_up  <= in_row;
            r_mid <= (last_idx == '0) ? in_row : r_mem[IDX_W'(0)];
            r_dn  <= (last_idx <= IDX_W'(1)) ? in_row : r_mem[IDX_W'(1)];
        end else if (advance) begin
            r_up  <= r_mid;
            r_mid <= r_dn;
            r_dn  <= r_mem[rd_addr];
        end
    end

    tlgs_row_eval #(
        .W     (W),
        .IDX_W (IDX_W)
    ) u_row_eval (
        .i_up        (r_up),
        .i_mid       (r_mid),
        .i_dn        (r_dn),
        .i_last_col  (last_idx),
        .i_side_mask (side_mask),
        .o_row       (eval_row)
    );

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_row  <= eval_row;
            r_out_last <= (r_y == last_idx);
        end
    end

    assign o_valid          = r_out_valid;
    assign o_next_row_cells = 64'(r_out_row);
    assign o_last_row       = r_out_last;

    a_rows_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rows_loaded <= last_idx)
        else $error("row load count beyond grid side");

    a_emit_from_row_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tlgs_pkg::ST_EMIT) |-> (r_rows_loaded == '0))
        else $error("rows counted during emission");

    a_full_grid_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (r_rows_loaded == last_idx))
            |=> (r_state == tlgs_pkg::ST_EMIT) && (r_y == '0))
        else $error("completed grid did not start emission at row zero");

endmodule

// ===== verif/tb_toroidal_life_generation_step_core.sv =====
// Testbench for toroidal_life_generation_step_core: loads Life grids row by row
// and checks every next-generation row against a predictor kept in this file.
// Depends on the design files and on tlgs_pkg only through the block's ports.
`timescale 1ns / 1ps

module tb_toroidal_life_generation_step_core;

    localparam int MAX_SIDE      = 64;
    localparam int SETTLE_CYCLES = 2 * MAX_SIDE + 8;
    localparam int RANDOM_ROWS   = 210;
    localparam int SHOW_LIMIT    = 10;

    typedef enum logic {
        DIR_CFG,
        DIR_ROW
    } t_dir_kind;

    typedef struct packed {
        t_dir_kind   kind;
        logic [63:0] value;
        logic        typed;
        logic [63:0] exp_cells;
        logic        exp_last;
    } t_dir_step;

    typedef struct packed {
        logic [63:0] cells;
        logic        is_last;
    } t_next_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_side_log2 = 3'd0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [63:0] i_row_cells = 64'd0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [63:0] o_next_row_cells;
    logic        o_last_row;

    // Predictor state: stored rows, rows loaded so far and the side register.
    logic [63:0] grid_mem [MAX_SIDE];
    logic [63:0] gen_cells [MAX_SIDE];
    int unsigned rows_in = 0;
    logic [2:0]  side_sel = 3'd6;

    t_next_row   next_rows_q [$];
    t_next_row   want;
    int          errors = 0;
    int          results_checked = 0;
    int          rows_sent = 0;
    int          generations = 0;
    logic [6:0]  sides_seen = '0;
    int          burst_left = 0;
    int          rx_mode = 0;
    int          rx_hold = 0;
    int          rx_run = 0;

    toroidal_life_generation_step_core #(
        .MAX_SIDE(MAX_SIDE)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_side_log2 (i_cfg_side_log2),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_row_cells     (i_row_cells),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_next_row_cells(o_next_row_cells),
        .o_last_row      (o_last_row)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d rows still expected.", next_rows_q.size());
        $display("FAILED: results differ");
        $finish;
    end

    function automatic int side_of(input logic [2:0] l2);
        int s;
        s = 1 << l2;
        if (s > MAX_SIDE) begin
            s = MAX_SIDE;
        end
        return s;
    endfunction

    // Stores one row; on the last row of the grid, computes the whole next
    // generation into gen_cells and returns its row count, else zero.
    task automatic load_row(input logic [63:0] cells, output int n);
        int          s, y, x, xl, xr, cnt;
        logic [63:0] mask, up, mid, dn, res;
        s = side_of(side_sel);
        mask = (s >= 64) ? '1 : ((64'd1 << s) - 64'd1);
        grid_mem[rows_in] = cells & mask;
        n = 0;
        if (rows_in + 1 < s) begin
            rows_in++;
            return;
        end
        rows_in = 0;
        for (y = 0; y < s; y++) begin
            up  = grid_mem[(y + s - 1) % s];
            mid = grid_mem[y];
            dn  = grid_mem[(y + 1) % s];
            res = '0;
            for (x = 0; x < s; x++) begin
                xl = (x + s - 1) % s;
                xr = (x + 1) % s;
                // On sides of one or two the wrapped positions land on the
                // same cells and each position still counts once.
                cnt = up[xl] + up[x] + up[xr] + mid[xl] + mid[xr]
                    + dn[xl] + dn[x] + dn[xr];
                res[x] = (cnt == 3) || (cnt == 2 && mid[x]);
            end
            gen_cells[y] = res;
        end
        n = s;
    endtask

    task automatic push_generation(input int n);
        int y;
        for (y = 0; y < n; y++) begin
            next_rows_q.push_back('{cells: gen_cells[y], is_last: (y == n - 1)});
        end
    endtask

    // Waits until the block has nothing left to deliver and has gone quiet.
    task automatic settle_block();
        if (i_valid) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        while (next_rows_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_side(input logic [2:0] l2);
        settle_block();
        @(negedge i_clk);
        i_cfg_valid     <= 1'b1;
        i_cfg_side_log2 <= l2;
        do @(posedge i_clk); while (!o_cfg_ready);
        side_sel = l2;
        rows_in  = 0;
        sides_seen[(l2 > 3'd6) ? 6 : l2] = 1'b1;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // The sender works in bursts; between bursts valid sometimes drops.
    task automatic send_row(input logic [63:0] cells, output int n);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_row_cells <= cells;
        do @(posedge i_clk); while (!o_ready);
        load_row(cells, n);
        rows_sent++;
        if (n > 0) begin
            generations++;
        end
    endtask

    function automatic logic [63:0] random_cells(input int density);
        logic [63:0] a, b, c;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        c = {$urandom, $urandom};
        case (density)
            0:       return a;
            1:       return a & b;
            2:       return a & b & c;
            default: return a | b;
        endcase
    endfunction

    function automatic logic [2:0] pick_side();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return 3'd0;
        if (r < 35) return 3'd1;
        if (r < 55) return 3'd2;
        if (r < 75) return 3'd3;
        if (r < 87) return 3'd4;
        if (r < 95) return 3'd5;
        return (r < 98) ? 3'd6 : 3'd7;
    endfunction

    // Receiver: a ready pattern whose mode is picked anew whenever its hold counter runs out.
    always @(negedge i_clk) begin
        if (rx_hold == 0) begin
            rx_mode <= $urandom_range(0, 2);
            rx_hold <= $urandom_range(20, 80);
        end else begin
            rx_hold <= rx_hold - 1;
        end
        case (rx_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= ($urandom_range(0, 3) != 0);
            default: begin
                if (rx_run == 0) begin
                    i_ready <= ~i_ready;
                    rx_run  <= $urandom_range(1, 12);
                end else begin
                    rx_run <= rx_run - 1;
                end
            end
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            results_checked++;
            if (next_rows_q.size() == 0) begin
                if (errors < SHOW_LIMIT) begin
                    $display("Unexpected row %h last %b", o_next_row_cells, o_last_row);
                end
                errors++;
            end else begin
                want = next_rows_q.pop_front();
                if (o_next_row_cells !== want.cells || o_last_row !== want.is_last) begin
                    if (errors < SHOW_LIMIT) begin
                        $display("Row mismatch: expected %h last %b, got %h last %b",
                                 want.cells, want.is_last, o_next_row_cells, o_last_row);
                    end
                    errors++;
                end
            end
        end
    end

    initial begin : stimulus
        t_dir_step   dir_steps [25];
        logic [2:0]  l2;
        int          i, n, s, r, gens, density, partial, phase, random_rows;

        dir_steps = '{
            '{DIR_CFG, 64'd0,                 1'b0, 64'd0, 1'b0},
            '{DIR_ROW, 64'd0,                 1'b1, 64'd0, 1'b1},
            // A lone cell on a side of one sees itself eight times and dies.
            '{DIR_ROW, 64'd1,                 1'b1, 64'd0, 1'b1},
            '{DIR_ROW, '1,                    1'b1, 64'd0, 1'b1},
            '{DIR_CFG, 64'd1,                 1'b0, 64'd0, 1'b0},
            '{DIR_ROW, 64'h3,                 1'b0, 64'd0, 1'b0},
            '{DIR_ROW, 64'h1,                 1'b0, 64'd0, 1'b0},
            '{DIR_ROW, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 64'd0, 1'b0},
            '{DIR_ROW, 64'hFFFF_FFFF_FFFF_FFFC, 1'b0, 64'd0, 1'b0},
            '{DIR_CFG, 64'd2,                 1'b0, 64'd0, 1'b0},
            '{DIR_ROW, 64'h0,                 1'b0, 64'd0, 1'b0},
            '{DIR_ROW, 64'h7,                 1'b0, 64'd0, 1'b0},
            '{DIR_ROW, 64'h0,                 1'b0, 64'd0, 1'b0},
            '{DIR_ROW, 64'h0,                 1'b0, 64'd0, 1'b0},
            // Two rows of a grid left unfinished; the write that follows
            // restarts loading at row 0 with a new side.
            '{DIR_ROW, 64'hF,                 1'b0, 64'd0, 1'b0},
            '{DIR_ROW, 64'h9,                 1'b0, 64'd0, 1'b0},
            '{DIR_CFG, 64'd3,                 1'b0, 64'd0, 1'b0},
            '{DIR_ROW, 64'h02,                1'b0, 64'd0, 1'b0},
            '{DIR_ROW, 64'h04,                1'b0, 64'd0, 1'b0},
            '{DIR_ROW, 64'h07,                1'b0, 64'd0, 1'b0},
            '{DIR_ROW, 64'h00,                1'b0, 64'd0, 1'b0},
            '{DIR_ROW, 64'h00,                1'b0, 64'd0, 1'b0},
            '{DIR_ROW, 64'h00,                1'b0, 64'd0, 1'b0},
            '{DIR_ROW, 64'h00,                1'b0, 64'd0, 1'b0},
            '{DIR_ROW, 64'h81,                1'b0, 64'd0, 1'b0}
        };

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < 25; i++) begin
            if (dir_steps[i].kind == DIR_CFG) begin
                write_side(dir_steps[i].value[2:0]);
            end else begin
                send_row(dir_steps[i].value, n);
                if (dir_steps[i].typed) begin
                    next_rows_q.push_back('{cells: dir_steps[i].exp_cells,
                                            is_last: dir_steps[i].exp_last});
                end else begin
                    push_generation(n);
                end
            end
        end

        // Random part: well-formed grids with random content, the first one
        // at an oversized side setting, plus an occasional unfinished grid.
        phase = 0;
        random_rows = 0;
        while (random_rows < RANDOM_ROWS) begin
            l2 = (phase == 0) ? 3'd7 : pick_side();
            write_side(l2);
            s = side_of(l2);
            gens = (s <= 8) ? $urandom_range(1, 3) : 1;
            repeat (gens) begin
                density = $urandom_range(0, 3);
                for (r = 0; r < s; r++) begin
                    send_row(random_cells(density), n);
                    push_generation(n);
                    random_rows++;
                end
            end
            if (s > 1 && $urandom_range(0, 4) == 0) begin
                partial = $urandom_range(1, (s - 1 < 8) ? s - 1 : 8);
                repeat (partial) begin
                    send_row(random_cells(0), n);
                    push_generation(n);
                    random_rows++;
                end
            end
            phase++;
        end

        settle_block();
        $display("Sent %0d rows forming %0d generations; checked %0d result rows.",
                 rows_sent, generations, results_checked);
        $display("Side settings exercised (bit per log2 side): %b", sides_seen);
        if (errors == 0 && next_rows_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches, %0d rows never delivered", errors, next_rows_q.size());
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/tlgs_pkg.sv
design/tlgs_cell.sv
design/tlgs_row_eval.sv
design/toroidal_life_generation_step_core.sv
verif/tb_toroidal_life_generation_step_core.sv
